@@ rtl/core/rcp_pkg.sv @@
// Shared types, character codes and token helper functions for the remote command parser.
package rcp_pkg;

    localparam int unsigned CMD_BYTES_DEF = 32;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_S     = 8'h73;

    localparam logic [16:0] MAG_LIMIT  = 17'd32768;
    localparam logic [15:0] POS_MAX    = 16'h7FFF;
    localparam logic [2:0]  FIELD_LAST = 3'd7;

    typedef enum logic [3:0] {
        PH_BETWEEN = 4'b0001,
        PH_LEAD    = 4'b0010,
        PH_DIGITS  = 4'b0100,
        PH_DONE    = 4'b1000
    } phase_t;

    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_SERVO = 2'd1,
        KIND_DRIVE = 2'd2,
        KIND_OTHER = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        EV_NONE     = 3'd0,
        EV_SERVO    = 3'd1,
        EV_DRIVE    = 3'd2,
        EV_UNKNOWN  = 3'd3,
        EV_OVERFLOW = 3'd4
    } event_t;

    typedef struct packed {
        logic [2:0]       field_index;
        phase_t           phase;
        logic [16:0]      accum;
        logic             negative;
        kind_t            kind;
        logic             text_ended;
        logic [2:0][15:0] pend;
        logic [2:0]       pend_valid;
    } parse_t;

    typedef struct packed {
        logic [2:0]       servo_wr;
        logic [1:0]       drive_wr;
        logic [2:0][15:0] vals;
        event_t           ev;
    } commit_t;

    localparam parse_t PARSE_CLEAR = '{
        field_index: 3'd0,
        phase:       PH_BETWEEN,
        accum:       17'd0,
        negative:    1'b0,
        kind:        KIND_NONE,
        text_ended:  1'b0,
        pend:        '0,
        pend_valid:  3'd0
    };

    function automatic logic [16:0] add_digit(logic [16:0] acc, logic [7:0] c);
        logic [19:0] sum;
        sum = ({3'b000, acc} << 3) + ({3'b000, acc} << 1) + {16'd0, c[3:0]};
        if (sum > {3'b000, MAG_LIMIT})
        begin
            return MAG_LIMIT;
        end
        return sum[16:0];
    endfunction

    function automatic parse_t finish_token(parse_t s);
        parse_t     r;
        logic [15:0] v;
        logic [1:0]  idx;
        r = s;
        if (s.phase != PH_BETWEEN)
        begin
            if (s.field_index inside {[3'd1:3'd3]})
            begin
                if (s.negative)
                begin
                    v = 16'(17'd0 - s.accum);
                end
                else if (s.accum > {1'b0, POS_MAX})
                begin
                    v = POS_MAX;
                end
                else
                begin
                    v = s.accum[15:0];
                end
                idx = 2'(s.field_index - 3'd1);
                r.pend[idx] = v;
                r.pend_valid[idx] = 1'b1;
            end
            if (s.field_index != FIELD_LAST)
            begin
                r.field_index = s.field_index + 3'd1;
            end
            r.phase    = PH_BETWEEN;
            r.accum    = 17'd0;
            r.negative = 1'b0;
        end
        return r;
    endfunction

    function automatic parse_t feed_char(parse_t s, logic [7:0] c);
        parse_t r;
        logic   digit;
        logic   space;
        r = s;
        digit = c inside {[CH_ZERO:CH_NINE]};
        space = (c == CH_SPACE) || (c inside {[CH_TAB:CH_CR]});
        if (r.phase == PH_BETWEEN)
        begin
            if (r.field_index == 3'd0)
            begin
                if (c == CH_S)
                begin
                    r.kind = KIND_SERVO;
                end
                else if (c == CH_R)
                begin
                    r.kind = KIND_DRIVE;
                end
                else
                begin
                    r.kind = KIND_OTHER;
                end
            end
            r.phase = PH_LEAD;
        end
        case (r.phase)
            PH_LEAD:
            begin
                if (space)
                begin
                    r.phase = PH_LEAD;
                end
                else if (c == CH_PLUS)
                begin
                    r.phase = PH_DIGITS;
                end
                else if (c == CH_MINUS)
                begin
                    r.negative = 1'b1;
                    r.phase    = PH_DIGITS;
                end
                else if (digit)
                begin
                    r.accum = add_digit(r.accum, c);
                    r.phase = PH_DIGITS;
                end
                else
                begin
                    r.phase = PH_DONE;
                end
            end
            PH_DIGITS:
            begin
                if (digit)
                begin
                    r.accum = add_digit(r.accum, c);
                end
                else
                begin
                    r.phase = PH_DONE;
                end
            end
            default:
            begin
                r.phase = r.phase;
            end
        endcase
        return r;
    endfunction

endpackage

@@ rtl/core/remote_command_parser.sv @@
// Top level of the remote command parser: byte stream in, committed settings and event out.
// A result transaction is registered and appears in the cycle after its byte is accepted.
// One byte per cycle unless output stalls; a single pass of logic updates the parse state.
// A waiting result does not stall input while the downstream side takes it that cycle.
// Reset (asynchronous, active low) clears the parse state and the committed values,
// with laser_on reset to zero.
module remote_command_parser #(
    parameter int unsigned CMD_BYTES = rcp_pkg::CMD_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [15:0] servo_x, [31:16] servo_y, [32] laser_on, [48:33] drive_radius,
    // [64:49] drive_speed, [67:65] cmd_event, [71:68] zero
    output logic [71:0] m_axis_tdata
);
    import rcp_pkg::*;

    localparam int unsigned CNT_W = $clog2(CMD_BYTES);

    logic             in_acc;
    logic [CNT_W-1:0] byte_count_reg;
    logic [CNT_W-1:0] byte_count_next;
    parse_t           parse_reg;
    parse_t           parse_next;
    commit_t          commit;

    logic             out_valid_reg;
    logic             out_valid_next;
    logic [15:0]      servo_x_reg;
    logic [15:0]      servo_x_next;
    logic [15:0]      servo_y_reg;
    logic [15:0]      servo_y_next;
    logic             laser_on_reg;
    logic             laser_on_next;
    logic [15:0]      drive_radius_reg;
    logic [15:0]      drive_radius_next;
    logic [15:0]      drive_speed_reg;
    logic [15:0]      drive_speed_next;
    event_t           event_reg;
    event_t           event_next;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    rcp_step #(
        .CMD_BYTES(CMD_BYTES)
    ) u_step (
        .rx_byte        (s_axis_tdata),
        .byte_count     (byte_count_reg),
        .parse_cur      (parse_reg),
        .byte_count_upd (byte_count_next),
        .parse_upd      (parse_next),
        .commit         (commit)
    );

    always_comb
    begin
        out_valid_next    = out_valid_reg && !m_axis_tready;
        servo_x_next      = servo_x_reg;
        servo_y_next      = servo_y_reg;
        laser_on_next     = laser_on_reg;
        drive_radius_next = drive_radius_reg;
        drive_speed_next  = drive_speed_reg;
        event_next        = event_reg;
        if (in_acc)
        begin
            out_valid_next = 1'b1;
            event_next     = commit.ev;
            if (commit.servo_wr[0])
            begin
                servo_x_next = commit.vals[0];
            end
            if (commit.servo_wr[1])
            begin
                servo_y_next = commit.vals[1];
            end
            if (commit.servo_wr[2])
            begin
                laser_on_next = (commit.vals[2] == 16'd0);
            end
            if (commit.drive_wr[0])
            begin
                drive_radius_next = commit.vals[0];
            end
            if (commit.drive_wr[1])
            begin
                drive_speed_next = commit.vals[1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg   <= '0;
            parse_reg        <= PARSE_CLEAR;
            out_valid_reg    <= 1'b0;
            servo_x_reg      <= 16'd0;
            servo_y_reg      <= 16'd0;
            laser_on_reg     <= 1'b0;
            drive_radius_reg <= 16'd0;
            drive_speed_reg  <= 16'd0;
            event_reg        <= EV_NONE;
        end
        else
        begin
            if (in_acc)
            begin
                byte_count_reg <= byte_count_next;
                parse_reg      <= parse_next;
            end
            out_valid_reg    <= out_valid_next;
            servo_x_reg      <= servo_x_next;
            servo_y_reg      <= servo_y_next;
            laser_on_reg     <= laser_on_next;
            drive_radius_reg <= drive_radius_next;
            drive_speed_reg  <= drive_speed_next;
            event_reg        <= event_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'd0, event_reg, drive_speed_reg, drive_radius_reg,
                            laser_on_reg, servo_y_reg, servo_x_reg};

    a_star_clears : assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && (s_axis_tdata == CH_STAR) |=>
        (byte_count_reg == '0) && (parse_reg.field_index == 3'd0)
        && (parse_reg.pend_valid == 3'd0))
        else $error("parse state not cleared after a command end");

    a_overflow_clears : assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && (commit.ev == EV_OVERFLOW) |=> (byte_count_reg == '0))
        else $error("byte count not cleared after an overflow");

    a_values_hold : assert property (@(posedge clk) disable iff (!rst_n)
        !in_acc |=> $stable(m_axis_tdata))
        else $error("result changed without an accepted transaction");

    a_commit_event : assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && (commit.servo_wr != 3'd0) |=> (event_reg == EV_SERVO))
        else $error("servo values written without a servo event");

endmodule

@@ rtl/core/rcp_step.sv @@
// Next-state logic of the parser for one received byte, with the commit decision.
module rcp_step #(
    parameter int unsigned CMD_BYTES = rcp_pkg::CMD_BYTES_DEF
) (
    input  logic [7:0]                     rx_byte,
    input  logic [$clog2(CMD_BYTES)-1:0]   byte_count,
    input  rcp_pkg::parse_t                parse_cur,
    output logic [$clog2(CMD_BYTES)-1:0]   byte_count_upd,
    output rcp_pkg::parse_t                parse_upd,
    output rcp_pkg::commit_t               commit
);
    import rcp_pkg::*;

    localparam int unsigned CNT_W = $clog2(CMD_BYTES);
    localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(CMD_BYTES - 1);

    parse_t s;

    always_comb
    begin
        s = parse_cur;
        byte_count_upd = byte_count;
        commit = '{servo_wr: 3'd0, drive_wr: 2'd0, vals: '0, ev: EV_NONE};
        if (byte_count >= CNT_LIMIT)
        begin
            s = PARSE_CLEAR;
            byte_count_upd = '0;
            commit.ev = EV_OVERFLOW;
        end
        else
        begin
            byte_count_upd = byte_count + 1'b1;
            if (!s.text_ended)
            begin
                if (rx_byte == CH_NUL)
                begin
                    s.text_ended = 1'b1;
                end
                else if (rx_byte == CH_COMMA)
                begin
                    s = finish_token(s);
                end
                else
                begin
                    s = feed_char(s, rx_byte);
                end
            end
            if (rx_byte == CH_STAR)
            begin
                s = finish_token(s);
                commit.vals = s.pend;
                case (s.kind)
                    KIND_SERVO:
                    begin
                        commit.servo_wr = s.pend_valid;
                        commit.ev = EV_SERVO;
                    end
                    KIND_DRIVE:
                    begin
                        commit.drive_wr = s.pend_valid[1:0];
                        commit.ev = EV_DRIVE;
                    end
                    default:
                    begin
                        commit.ev = EV_UNKNOWN;
                    end
                endcase
                s = PARSE_CLEAR;
                byte_count_upd = '0;
            end
        end
        parse_upd = s;
    end

endmodule

@@ tb/sv/tb_remote_command_parser.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the remote command parser: directed and random byte streams.
module tb_remote_command_parser;
    import rcp_pkg::*;

    localparam int N_DIR        = 23;
    localparam int RANDOM_ITEMS = 1380;
    localparam int STALL_CYCLES = 400;

    typedef struct {
        logic signed [15:0] sx;
        logic signed [15:0] sy;
        logic               laser;
        logic signed [15:0] rad;
        logic signed [15:0] spd;
        event_t             ev;
    } status_t;

    typedef struct {
        logic [7:0] rx;
        event_t     ev;
    } dir_row_t;

    logic        clk;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'd0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;

    logic        row_typed = 1'b0;
    event_t      row_ev    = EV_NONE;
    int          tx_idle_pct;
    int          rx_idle_pct = 0;
    logic        hold_req    = 1'b0;
    logic        hold_used   = 1'b0;
    int          hold_left   = 0;
    int          sent_count  = 0;
    int          failures    = 0;
    status_t     expected_q[$];
    logic [7:0]  cmd_bytes[$];

    int                 cmd_len;
    int                 tok_field;
    phase_t             tok_phase;
    int                 tok_mag;
    logic               tok_neg;
    kind_t              kind_seen;
    logic               text_done;
    logic signed [15:0] pend_val [3];
    logic               pend_seen [3];
    logic signed [15:0] held [5];

    dir_row_t dir_rows [N_DIR] = '{
        '{CH_S, EV_NONE}, '{CH_COMMA, EV_NONE}, '{CH_MINUS, EV_NONE},
        '{"4", EV_NONE}, '{"0", EV_NONE}, '{"0", EV_NONE}, '{"0", EV_NONE},
        '{"0", EV_NONE}, '{CH_COMMA, EV_NONE}, '{"9", EV_NONE}, '{"9", EV_NONE},
        '{"9", EV_NONE}, '{"9", EV_NONE}, '{"9", EV_NONE}, '{CH_COMMA, EV_NONE},
        '{"0", EV_NONE}, '{CH_STAR, EV_SERVO},
        '{CH_R, EV_NONE}, '{CH_COMMA, EV_NONE}, '{CH_STAR, EV_DRIVE},
        '{CH_NUL, EV_NONE}, '{8'hFF, EV_NONE}, '{CH_STAR, EV_UNKNOWN}
    };

    remote_command_parser DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #3ms;
        $display("remote_command_parser: mismatch");
        $finish;
    end

    function automatic void restart_command();
        cmd_len   = 0;
        tok_field = 0;
        tok_phase = PH_BETWEEN;
        tok_mag   = 0;
        tok_neg   = 1'b0;
        kind_seen = KIND_NONE;
        text_done = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            pend_val[i]  = 16'sd0;
            pend_seen[i] = 1'b0;
        end
    endfunction

    function automatic void close_token();
        logic signed [15:0] v;
        if (tok_phase == PH_BETWEEN)
        begin
            return;
        end
        if (tok_field >= 1 && tok_field <= 3)
        begin
            if (tok_neg)
            begin
                v = 16'(-tok_mag);
            end
            else if (tok_mag > int'(POS_MAX))
            begin
                v = POS_MAX;
            end
            else
            begin
                v = 16'(tok_mag);
            end
            pend_val[tok_field - 1]  = v;
            pend_seen[tok_field - 1] = 1'b1;
        end
        if (tok_field < int'(FIELD_LAST))
        begin
            tok_field++;
        end
        tok_phase = PH_BETWEEN;
        tok_mag   = 0;
        tok_neg   = 1'b0;
    endfunction

    function automatic void push_digit(logic [7:0] c);
        tok_mag = tok_mag * 10 + (int'(c) - int'(CH_ZERO));
        if (tok_mag > int'(MAG_LIMIT))
        begin
            tok_mag = int'(MAG_LIMIT);
        end
    endfunction

    function automatic status_t predict_byte(logic [7:0] b);
        status_t r;
        event_t  ev;
        logic    is_digit;
        logic    is_space;
        ev       = EV_NONE;
        is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
        is_space = (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
        if (cmd_len >= int'(CMD_BYTES_DEF) - 1)
        begin
            restart_command();
            ev = EV_OVERFLOW;
        end
        else
        begin
            cmd_len++;
            if (!text_done)
            begin
                if (b == CH_NUL)
                begin
                    text_done = 1'b1;
                end
                else if (b == CH_COMMA)
                begin
                    close_token();
                end
                else
                begin
                    if (tok_phase == PH_BETWEEN)
                    begin
                        if (tok_field == 0)
                        begin
                            if (b == CH_S)
                            begin
                                kind_seen = KIND_SERVO;
                            end
                            else if (b == CH_R)
                            begin
                                kind_seen = KIND_DRIVE;
                            end
                            else
                            begin
                                kind_seen = KIND_OTHER;
                            end
                        end
                        tok_phase = PH_LEAD;
                    end
                    if (tok_phase == PH_LEAD)
                    begin
                        if (b == CH_PLUS)
                        begin
                            tok_phase = PH_DIGITS;
                        end
                        else if (b == CH_MINUS)
                        begin
                            tok_neg   = 1'b1;
                            tok_phase = PH_DIGITS;
                        end
                        else if (is_digit)
                        begin
                            push_digit(b);
                            tok_phase = PH_DIGITS;
                        end
                        else if (!is_space)
                        begin
                            tok_phase = PH_DONE;
                        end
                    end
                    else if (tok_phase == PH_DIGITS)
                    begin
                        if (is_digit)
                        begin
                            push_digit(b);
                        end
                        else
                        begin
                            tok_phase = PH_DONE;
                        end
                    end
                end
            end
            if (b == CH_STAR)
            begin
                close_token();
                if (kind_seen == KIND_SERVO)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        if (pend_seen[i])
                        begin
                            held[i] = pend_val[i];
                        end
                    end
                    ev = EV_SERVO;
                end
                else if (kind_seen == KIND_DRIVE)
                begin
                    for (int i = 0; i < 2; i++)
                    begin
                        if (pend_seen[i])
                        begin
                            held[3 + i] = pend_val[i];
                        end
                    end
                    ev = EV_DRIVE;
                end
                else
                begin
                    ev = EV_UNKNOWN;
                end
                restart_command();
            end
        end
        r.sx    = held[0];
        r.sy    = held[1];
        r.laser = (held[2] == 16'sd0);
        r.rad   = held[3];
        r.spd   = held[4];
        r.ev    = ev;
        return r;
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic typed, input event_t ev);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        row_typed     <= typed;
        row_ev        <= ev;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        sent_count++;
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else if (hold_req && !hold_used)
        begin
            hold_used     <= 1'b1;
            hold_left     <= STALL_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    always @(posedge clk)
    begin : scoreboard
        status_t want;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                want = predict_byte(s_axis_tdata);
                if (row_typed)
                begin
                    want.ev = row_ev;
                end
                expected_q.push_back(want);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("result transaction with no expectation waiting");
                    failures++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    check_field("servo_x", want.sx, $signed(m_axis_tdata[15:0]));
                    check_field("servo_y", want.sy, $signed(m_axis_tdata[31:16]));
                    check_field("laser_on", want.laser, m_axis_tdata[32]);
                    check_field("drive_radius", want.rad, $signed(m_axis_tdata[48:33]));
                    check_field("drive_speed", want.spd, $signed(m_axis_tdata[64:49]));
                    check_field("cmd_event", want.ev, m_axis_tdata[67:65]);
                    check_field("pad", 0, m_axis_tdata[71:68]);
                end
            end
        end
    end

    initial
    begin
        int roll;
        int nf;
        int nd;
        int waited;
        restart_command();
        held = '{16'sd0, 16'sd0, 16'sd1, 16'sd0, 16'sd0};
        tx_idle_pct = 23;
        rx_idle_pct <= 78;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < N_DIR; r++)
        begin
            send_byte(dir_rows[r].rx, 1'b1, dir_rows[r].ev);
        end

        for (int ph = 0; ph < 3; ph++)
        begin
            if (ph == 1)
            begin
                tx_idle_pct = 78;
                rx_idle_pct <= 23;
            end
            else if (ph == 2)
            begin
                tx_idle_pct = 0;
                rx_idle_pct <= 0;
                hold_req    <= 1'b1;
            end
            while (sent_count < N_DIR + (ph + 1) * RANDOM_ITEMS / 3)
            begin
                cmd_bytes.delete();
                if ($urandom_range(0, 99) < 8)
                begin
                    repeat ($urandom_range(1, 12))
                    begin
                        cmd_bytes.push_back(8'($urandom_range(0, 255)));
                    end
                    if ($urandom_range(0, 1) == 1)
                    begin
                        cmd_bytes.push_back(CH_STAR);
                    end
                end
                else
                begin
                    if ($urandom_range(0, 99) < 30)
                    begin
                        repeat ($urandom_range(1, 2)) cmd_bytes.push_back(CH_COMMA);
                    end
                    roll = $urandom_range(0, 99);
                    if (roll < 45)
                    begin
                        cmd_bytes.push_back(CH_S);
                    end
                    else if (roll < 90)
                    begin
                        cmd_bytes.push_back(CH_R);
                    end
                    else
                    begin
                        cmd_bytes.push_back(8'($urandom_range(0, 255)));
                    end
                    if ($urandom_range(0, 99) < 25)
                    begin
                        repeat ($urandom_range(1, 3))
                        begin
                            cmd_bytes.push_back(8'($urandom_range(8'h61, 8'h7A)));
                        end
                    end
                    nf = $urandom_range(0, 5);
                    for (int f = 0; f < nf; f++)
                    begin
                        cmd_bytes.push_back(CH_COMMA);
                        if ($urandom_range(0, 99) < 10)
                        begin
                            cmd_bytes.push_back(CH_COMMA);
                        end
                        if ($urandom_range(0, 99) < 20)
                        begin
                            repeat ($urandom_range(1, 2))
                            begin
                                roll = $urandom_range(0, 5);
                                cmd_bytes.push_back((roll == 5) ? CH_SPACE : 8'(CH_TAB + roll));
                            end
                        end
                        roll = $urandom_range(0, 99);
                        if (roll < 20)
                        begin
                            cmd_bytes.push_back(CH_MINUS);
                        end
                        else if (roll < 30)
                        begin
                            cmd_bytes.push_back(CH_PLUS);
                        end
                        nd = ($urandom_range(0, 99) < 10) ? 0 : $urandom_range(1, 6);
                        repeat (nd) cmd_bytes.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
                        if ($urandom_range(0, 99) < 10)
                        begin
                            cmd_bytes.push_back(8'($urandom_range(8'h21, 8'h7E)));
                        end
                        if ($urandom_range(0, 99) < 3)
                        begin
                            cmd_bytes.push_back(CH_NUL);
                        end
                    end
                    if ($urandom_range(0, 99) < 6)
                    begin
                        repeat ($urandom_range(20, 40))
                        begin
                            if ($urandom_range(0, 1) == 1)
                            begin
                                cmd_bytes.push_back(CH_SPACE);
                            end
                            else
                            begin
                                cmd_bytes.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
                            end
                        end
                    end
                    if ($urandom_range(0, 99) < 95)
                    begin
                        cmd_bytes.push_back(CH_STAR);
                    end
                end
                foreach (cmd_bytes[i])
                begin
                    send_byte(cmd_bytes[i], 1'b0, EV_NONE);
                end
            end
        end

        s_axis_tvalid <= 1'b0;
        waited = 0;
        while (expected_q.size() != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (10) @(posedge clk);
        if (expected_q.size() != 0)
        begin
            $error("%0d expected result transactions never arrived", expected_q.size());
            failures++;
        end
        if (failures == 0)
        begin
            $display("remote_command_parser: match");
        end
        else
        begin
            $display("remote_command_parser: mismatch");
        end
        $finish;
    end

endmodule
